FILE: src/lfu_pkg.sv
// lfu_pkg: request/response payload types and state machine codes for lfu_cache_table.
// No dependencies.
`default_nettype none
package lfu_pkg;
	typedef struct packed {
		logic               req_type;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_AGE,
		ST_WRITE,
		ST_RESP
	} state_t;

	localparam logic        REQ_GET    = 1'b0;
	localparam logic        REQ_PUT    = 1'b1;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

FILE: src/lfu_ram.sv
// lfu_ram: generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module lfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

FILE: src/lfu_cache_table.sv
// lfu_cache_table: LFU key-value cache with LRU tie break, top level.
// Depends on lfu_pkg and lfu_ram.
`default_nettype none
// Channel  | dir | handshake         | payload
// req      | in  | req_valid/stall   | lfu_pkg::req_t (req_type, key, value)
// rsp      | out | rsp_valid/stall   | lfu_pkg::rsp_t (hit, read_value, evicted)
// cfg      | in  | cfg_valid/ready   | live_capacity[4:0]
//
// One request at a time. A request that writes the table passes through a match
// and victim search over the slot RAM, a decide step, a second pass over the
// same RAM port to age recency ranks (with a write-back for each aged entry),
// then the write. A get miss or a dropped put skips aging and write.
// Reset clears valid bits and occupancy at once; no clearing pass.
// A stalled response is held in its register; the next request is taken
// once it has left.
module lfu_cache_table #(
	parameter int CAPACITY    = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire lfu_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output lfu_pkg::rsp_t      rsp,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [4:0]    cfg_data
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RW = AW;              // recency rank width
	localparam int CW = COUNT_WIDTH;
	localparam int EW = 64 + CW + RW;    // key, value, count, rank
	localparam int OW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CMAX = {CW{1'b1}};

	lfu_pkg::state_t state_q, state_n;

	logic [CAPACITY-1:0] valid_q;
	logic [OW-1:0]       used_q;
	logic [4:0]          cap_q;
	lfu_pkg::req_t       req_q;
	logic [AW:0]         idx_q;      // sweep counter, one wider to pass the end
	logic                rd_pend_q;  // read data of idx-1 arrives this cycle
	logic [AW-1:0]       rd_idx_q;

	// Search results
	logic          hit_q, have_v_q, free_q;
	logic [AW-1:0] hit_s_q, vic_q, free_s_q;
	logic [CW-1:0] vic_cnt_q;
	logic [RW-1:0] vic_rank_q;
	logic [31:0]   hit_val_q;
	logic [CW-1:0] hit_cnt_q;
	logic [RW-1:0] hit_rank_q;

	// Decision
	logic          do_write_q, evict_q;
	logic [AW-1:0] tgt_q;
	logic [RW:0]   limit_q;          // one wider: "no limit" is CAPACITY
	logic [EW-1:0] tgt_word_q;

	// RAM
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	lfu_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	logic [31:0]   e_key, e_val;
	logic [CW-1:0] e_cnt;
	logic [RW-1:0] e_rank;
	assign {e_key, e_val, e_cnt, e_rank} = ram_rdata;

	logic [OW-1:0] cap_eff;
	assign cap_eff = (int'(cap_q) > CAPACITY) ? OW'(CAPACITY) : OW'(cap_q);

	logic sweep_done;
	assign sweep_done = (idx_q == (AW+1)'(CAPACITY));
	logic rd_ok;
	assign rd_ok = rd_pend_q && valid_q[rd_idx_q];

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != lfu_pkg::ST_IDLE);

	// table is written on any hit, and on a put miss unless storing is off
	function automatic logic do_write_n();
		do_write_n = hit_q || ((req_q.req_type == lfu_pkg::REQ_PUT) && (cap_eff != '0));
	endfunction

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			lfu_pkg::ST_IDLE:   if (req_valid) state_n = lfu_pkg::ST_SCAN;
			lfu_pkg::ST_SCAN:   if (sweep_done && !rd_pend_q) state_n = lfu_pkg::ST_DECIDE;
			lfu_pkg::ST_DECIDE: state_n = do_write_n() ? lfu_pkg::ST_AGE : lfu_pkg::ST_RESP;
			lfu_pkg::ST_AGE:    if (sweep_done && !rd_pend_q) state_n = lfu_pkg::ST_WRITE;
			lfu_pkg::ST_WRITE:  state_n = lfu_pkg::ST_RESP;
			lfu_pkg::ST_RESP:   if (!rsp_stall) state_n = lfu_pkg::ST_IDLE;
			default:            state_n = lfu_pkg::ST_IDLE;
		endcase
	end

	// RAM port use: address sweep in SCAN/AGE, writeback of aged ranks in AGE, target write in WRITE
	logic [RW-1:0] aged_rank;
	logic          age_hit;
	assign age_hit = (state_q == lfu_pkg::ST_AGE) && rd_ok && (rd_idx_q != tgt_q)
		&& ((RW+1)'(e_rank) < limit_q);
	assign aged_rank = e_rank + RW'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = idx_q[AW-1:0];
		ram_wdata = tgt_word_q;
		case (state_q)
			lfu_pkg::ST_AGE: begin
				if (age_hit) begin
					ram_we    = 1'b1;
					ram_addr  = rd_idx_q;
					ram_wdata = {e_key, e_val, e_cnt, aged_rank};
				end
			end
			lfu_pkg::ST_WRITE: begin
				ram_we   = 1'b1;
				ram_addr = tgt_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lfu_pkg::ST_IDLE;
			valid_q   <= '0;
			used_q    <= '0;
			cap_q     <= 5'd16;
			idx_q     <= '0;
			rd_pend_q <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			rd_pend_q <= ((state_q == lfu_pkg::ST_SCAN) || (state_q == lfu_pkg::ST_AGE))
				&& !sweep_done && !age_hit;
			case (state_q)
				lfu_pkg::ST_IDLE: idx_q <= '0;
				lfu_pkg::ST_SCAN, lfu_pkg::ST_AGE: begin
					if (!sweep_done && !age_hit) begin
						idx_q <= idx_q + (AW+1)'(1);
					end
				end
				lfu_pkg::ST_DECIDE: idx_q <= '0;
				lfu_pkg::ST_WRITE: begin
					if (do_write_q && !hit_q && !evict_q) begin
						valid_q[tgt_q] <= 1'b1;
						used_q         <= used_q + OW'(1);
					end
					rsp_valid <= 1'b1;
				end
				lfu_pkg::ST_RESP: if (!rsp_stall) rsp_valid <= 1'b0;
				default: ;
			endcase
			if (state_q == lfu_pkg::ST_DECIDE && !do_write_n()) rsp_valid <= 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_idx_q <= idx_q[AW-1:0];
		case (state_q)
			lfu_pkg::ST_IDLE: begin
				req_q    <= req;
				hit_q    <= 1'b0;
				have_v_q <= 1'b0;
				free_q   <= 1'b0;
			end
			lfu_pkg::ST_SCAN: begin
				if (rd_pend_q && !valid_q[rd_idx_q] && !free_q) begin
					free_q   <= 1'b1;
					free_s_q <= rd_idx_q;
				end
				if (rd_ok && e_key == req_q.key && !hit_q) begin
					hit_q      <= 1'b1;
					hit_s_q    <= rd_idx_q;
					hit_val_q  <= e_val;
					hit_cnt_q  <= e_cnt;
					hit_rank_q <= e_rank;
				end
				if (rd_ok && (!have_v_q || e_cnt < vic_cnt_q
						|| (e_cnt == vic_cnt_q && e_rank > vic_rank_q))) begin
					have_v_q   <= 1'b1;
					vic_q      <= rd_idx_q;
					vic_cnt_q  <= e_cnt;
					vic_rank_q <= e_rank;
				end
			end
			lfu_pkg::ST_DECIDE: begin
				do_write_q <= do_write_n();
				evict_q    <= !hit_q && (used_q >= cap_eff) && do_write_n();
				if (hit_q) begin
					tgt_q      <= hit_s_q;
					limit_q    <= {1'b0, hit_rank_q};
					tgt_word_q <= {req_q.key,
						(req_q.req_type == lfu_pkg::REQ_PUT) ? 32'(req_q.value) : hit_val_q,
						(hit_cnt_q == CMAX) ? hit_cnt_q : hit_cnt_q + CW'(1), RW'(0)};
				end else if (used_q >= cap_eff) begin
					tgt_q      <= vic_q;
					limit_q    <= {1'b0, vic_rank_q};
					tgt_word_q <= {req_q.key, req_q.value, CW'(1), RW'(0)};
				end else begin
					tgt_q      <= free_s_q;
					limit_q    <= (RW+1)'(CAPACITY);
					tgt_word_q <= {req_q.key, req_q.value, CW'(1), RW'(0)};
				end
			end
			default: ;
		endcase
	end

	// response register, filled in the decide step
	always_ff @(posedge clk) begin
		if (state_q == lfu_pkg::ST_DECIDE) begin
			rsp.hit <= hit_q;
			rsp.read_value <= (req_q.req_type == lfu_pkg::REQ_PUT) ? 32'sd0
				: (hit_q ? hit_val_q : lfu_pkg::MISS_VALUE);
			rsp.evicted <= !hit_q && (req_q.req_type == lfu_pkg::REQ_PUT)
				&& (cap_eff != '0) && (used_q >= cap_eff);
		end
	end
endmodule
`default_nettype wire

FILE: verif/lfu_cache_table_tb.sv
// lfu_cache_table_tb: self-checking testbench for the LFU cache table with LRU tie break.
// Depends on lfu_pkg and lfu_cache_table; a built-in cache predictor scores every response.
`default_nettype none
module lfu_cache_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS     = 16;
	localparam int COUNT_TOP = 16'hFFFF;

	// Cache predictor plus a queue of expected responses
	class lfu_scoreboard;
		bit          vld[SLOTS];
		logic [31:0] keys[SLOTS];
		logic [31:0] vals[SLOTS];
		int unsigned uses[SLOTS];
		int unsigned age[SLOTS];
		int unsigned occupied;
		int unsigned live_cap;
		lfu_pkg::rsp_t expected_rsp[$];
		int          errors;
		int          checked;
		int          hits;
		int          evictions;

		function new();
			foreach (vld[i]) vld[i] = 0;
			occupied = 0;
			live_cap = 16;
			errors   = 0;
			checked  = 0;
			hits     = 0;
			evictions = 0;
		endfunction

		// slot s becomes newest; valid slots younger than lim age by one
		function void promote(int s, int unsigned lim);
			for (int i = 0; i < SLOTS; i++)
				if (i != s && vld[i] && age[i] < lim) age[i]++;
			age[s] = 0;
		endfunction

		function void bump(int s);
			if (uses[s] < COUNT_TOP) uses[s]++;
			promote(s, age[s]);
		endfunction

		function void note_request(lfu_pkg::req_t r);
			lfu_pkg::rsp_t p;
			int          slot;
			int unsigned cap;
			int unsigned lim;
			bit          have;
			slot = -1;
			cap  = (live_cap > SLOTS) ? SLOTS : live_cap;
			p    = '0;
			for (int i = 0; i < SLOTS; i++)
				if (slot < 0 && vld[i] && keys[i] == r.key) slot = i;
			p.hit = (slot >= 0);
			if (r.req_type == lfu_pkg::REQ_GET) begin
				if (slot >= 0) begin
					p.read_value = vals[slot];
					bump(slot);
				end else
					p.read_value = lfu_pkg::MISS_VALUE;
			end else if (slot >= 0) begin
				vals[slot] = r.value;
				bump(slot);
			end else if (cap != 0) begin
				slot = 0;
				if (occupied >= cap) begin
					// lowest count wins, oldest among equals
					have = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (!vld[i]) continue;
						if (!have || uses[i] < uses[slot] ||
						    (uses[i] == uses[slot] && age[i] > age[slot])) begin
							slot = i;
							have = 1;
						end
					end
					p.evicted = 1;
					lim = age[slot];
				end else begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!vld[i]) slot = i;
					vld[slot] = 1;
					occupied++;
					lim = 32'hFFFF_FFFF;
				end
				keys[slot] = r.key;
				vals[slot] = r.value;
				uses[slot] = 1;
				promote(slot, lim);
			end
			hits += p.hit;
			evictions += p.evicted;
			expected_rsp.push_back(p);
		endfunction

		function void check_response(lfu_pkg::rsp_t a);
			lfu_pkg::rsp_t e;
			checked++;
			if (expected_rsp.size() == 0) begin
				$error("response with none outstanding: %p", a);
				errors++;
				return;
			end
			e = expected_rsp.pop_front();
			if (a.hit !== e.hit) begin
				$error("hit: expected %0b, got %0b", e.hit, a.hit);
				errors++;
			end
			if (a.read_value !== e.read_value) begin
				$error("read_value: expected %0d, got %0d", e.read_value, a.read_value);
				errors++;
			end
			if (a.evicted !== e.evicted) begin
				$error("evicted: expected %0b, got %0b", e.evicted, a.evicted);
				errors++;
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	lfu_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	lfu_pkg::rsp_t rsp;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [4:0]    cfg_data;

	lfu_scoreboard sb;
	int  send_idle_pct;		// chance in percent that the sender skips a cycle
	int  stall_pct;			// chance in percent that the receiver stalls
	bit  hold_off;			// long receiver hold-off in progress
	int  sent;
	bit  seen_full_stall;	// input stalled while holding off
	logic [31:0] key_pool[8];

	lfu_cache_table #(
		.CAPACITY   (SLOTS),
		.COUNT_WIDTH(16)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Response side: random stall, plus hold-off on demand
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
		if (arst_n && hold_off && req_valid && req_stall)
			seen_full_stall <= 1;
		rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
	end

	// Offer one request, honoring the sender idle rate; valid stays up after
	// the accepting edge until the next request or idle cycle replaces it
	task automatic send_request(input logic t, input logic [31:0] k, input logic [31:0] v);
		lfu_pkg::req_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		r.req_type = t;
		r.key      = k;
		r.value    = v;
		req_valid <= 1;
		req       <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(r);
		sent++;
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		req_valid <= 0;
		while (sb.expected_rsp.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	// Capacity write, only while idle
	task automatic set_capacity(input logic [4:0] c);
		wait_drained();
		cfg_valid <= 1;
		cfg_data  <= c;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		sb.live_cap = 32'(c);
	endtask

	// Random request, mostly on a small key set so hits and evictions happen
	task automatic random_request();
		logic [31:0] k;
		if ($urandom_range(9) < 8)
			k = key_pool[$urandom_range(7)] + $urandom_range(2);
		else
			k = $urandom;
		send_request(1'($urandom_range(1)), k, $urandom);
	endtask

	task automatic random_phase(input int n, input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct     = stall;
		repeat (n) random_request();
	endtask

	initial begin
		sb              = new();
		arst_n          = 0;
		req_valid       = 0;
		req             = '0;
		rsp_stall       = 0;
		cfg_valid       = 0;
		cfg_data        = 5'd16;
		send_idle_pct   = 0;
		stall_pct       = 0;
		hold_off        = 0;
		sent            = 0;
		seen_full_stall = 0;
		foreach (key_pool[i]) key_pool[i] = $urandom;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFD;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, miss, hit, update, evict with LRU tie break
		send_request(lfu_pkg::REQ_GET, 32'h8000_0000, 0);
		send_request(lfu_pkg::REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(lfu_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(lfu_pkg::REQ_PUT, 32'h0, 32'h0);
		send_request(lfu_pkg::REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(lfu_pkg::REQ_GET, 32'h7FFF_FFFF, 0);
		send_request(lfu_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
		send_request(lfu_pkg::REQ_GET, 32'h7FFF_FFFF, 0);
		set_capacity(5'd2);	// now below occupancy: one eviction per put miss
		send_request(lfu_pkg::REQ_PUT, 32'h55, 32'hAAAA_5555);
		send_request(lfu_pkg::REQ_PUT, 32'h66, 32'h5555_AAAA);
		send_request(lfu_pkg::REQ_GET, 32'h0, 0);
		set_capacity(5'd0);	// misses on puts dropped, hits still work
		send_request(lfu_pkg::REQ_PUT, 32'h77, 1);
		send_request(lfu_pkg::REQ_GET, 32'h77, 0);
		send_request(lfu_pkg::REQ_PUT, 32'h66, 7);
		send_request(lfu_pkg::REQ_GET, 32'h66, 0);
		set_capacity(5'd31);	// above the table acts as full size
		for (int i = 0; i < 18; i++)
			send_request(lfu_pkg::REQ_PUT, 32'h100 + i, i);

		// Repeated touches on one key, then pressure on the rest
		send_request(lfu_pkg::REQ_PUT, 32'h7FFF_FFFE, 3);
		repeat (20) send_request(lfu_pkg::REQ_GET, 32'h7FFF_FFFE, 0);
		send_request(lfu_pkg::REQ_PUT, 32'h200, 4);
		send_request(lfu_pkg::REQ_PUT, 32'h7FFF_FFFE, 5);

		random_phase(150, 0, 0);
		set_capacity(5'd1);
		random_phase(150, 66, 0);
		set_capacity(5'd4);
		random_phase(150, 0, 66);
		set_capacity(5'd16);
		random_phase(150, 32, 32);

		// Hold off the receiver while requests keep coming
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				random_phase(6, 0, 0);
				req_valid <= 0;
			end
		join
		set_capacity(5'd0);
		random_phase(60, 10, 10);
		set_capacity(5'd9);
		random_phase(200, 20, 20);
		set_capacity(5'd16);
		random_phase(130, 0, 0);

		wait_drained();
		$display("Sent %0d requests, %0d responses checked, %0d hits, %0d evictions.",
			sent, sb.checked, sb.hits, sb.evictions);
		$display("Capacities 0,1,2,4,9,16,31 covered; repeated touches and full-stall hold-off %0s.",
			seen_full_stall ? "reached" : "attempted");
		if (sb.errors == 0 && sb.expected_rsp.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// About 1050 requests plus stalls; a timeout ends the run as a mismatch
	initial begin
		#4ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
src/lfu_pkg.sv
src/lfu_ram.sv
src/lfu_cache_table.sv
verif/lfu_cache_table_tb.sv
